### design/sgpd_pkg.sv
// Package for the simple glyph point decoder.
// Holds the item type, flag bit positions and result status codes.
// No dependencies.
package sgpd_pkg;

  // One input byte with its end-of-record mark
  typedef struct packed {
    logic [7:0] data_byte;
    logic       record_end;
  } item_t;

  // Flag byte bit positions
  localparam int FLAG_ON     = 0;
  localparam int FLAG_X_BYTE = 1;
  localparam int FLAG_Y_BYTE = 2;
  localparam int FLAG_RUN    = 3;
  localparam int FLAG_X_SAME = 4;
  localparam int FLAG_Y_SAME = 5;

  localparam logic [3:0] HEADER_BYTES = 4'd10;

  // Result status codes
  typedef enum logic [2:0] {
    ST_POINT     = 3'd0,
    ST_COMPOUND  = 3'd1,
    ST_UNORDERED = 3'd2,
    ST_LIMIT     = 3'd3,
    ST_OVERRUN   = 3'd4,
    ST_TRUNCATED = 3'd5,
    ST_EMPTY     = 3'd6
  } status_t;

endpackage

### design/sgpd_if.sv
// Channel interfaces of the simple glyph point decoder.
// Depends on nothing; valid/ready handshake with payload.
interface sgpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       record_end;

  modport source (output valid, output data_byte, output record_end, input ready);
  modport sink (input valid, input data_byte, input record_end, output ready);
endinterface

interface sgpd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic               curve_pt;
  logic               closes_contour;
  logic [2:0]         status;
  logic               last;

  modport source (output valid, output point_x, output point_y, output curve_pt,
                  output closes_contour, output status, output last, input ready);
  modport sink (input valid, input point_x, input point_y, input curve_pt,
                input closes_contour, input status, input last, output ready);
endinterface

### design/sgpd_front.sv
// Front end: two-entry byte queue between the input channel and the decoder.
// Depends on sgpd_pkg.
module sgpd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sgpd_pkg::item_t    in_item,
  output logic               q_valid,
  output sgpd_pkg::item_t    q_item,
  input  logic               q_pop
);

  sgpd_pkg::item_t q_mem [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_mem[rd_ptr_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr_r] <= in_item;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
`endif

endmodule

### design/sgpd_back.sv
// Back end: glyph parser sequencer with flag, x and endpoint stores and
// the result register. Depends on sgpd_pkg and sgpd_out_if.
module sgpd_back #(
  parameter int MAX_POINTS   = 64,
  parameter int MAX_CONTOURS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  sgpd_pkg::item_t    q_item,
  output logic               q_pop,
  sgpd_out_if.source         out_ch
);

  localparam int PW  = $clog2(MAX_POINTS + 1);
  localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW  = $clog2(MAX_CONTOURS + 1);
  localparam int EAW = (MAX_CONTOURS > 1) ? $clog2(MAX_CONTOURS) : 1;
  localparam logic [16:0] MAXP17 = 17'(MAX_POINTS);
  localparam logic [15:0] MAXC16 = 16'(MAX_CONTOURS);

  typedef enum logic [3:0] {
    PH_HEADER, PH_ENDPTS, PH_INSTLEN, PH_INSTR, PH_FLAGS,
    PH_REPEAT, PH_X, PH_Y, PH_DRAIN
  } phase_t;

  typedef enum logic [2:0] {
    SQ_IDLE, SQ_FILL, SQ_CHX, SQ_CHY, SQ_END
  } seq_t;

  // stores
  logic [7:0]  flag_mem [MAX_POINTS];
  logic [31:0] x_mem    [MAX_POINTS];
  logic [15:0] ep_mem   [MAX_CONTOURS];

  // registers
  phase_t             phase_r, phase_nxt;
  seq_t               seq_r, seq_nxt;
  logic [15:0]        bc_r, bc_nxt;
  logic [15:0]        ct_r, ct_nxt;
  logic signed [16:0] prev_r, prev_nxt;
  logic [15:0]        skip_r, skip_nxt;
  logic [PW-1:0]      pidx_r, pidx_nxt;
  logic [PW-1:0]      total_r, total_nxt;
  logic [CW-1:0]      cidx_r, cidx_nxt;
  logic [31:0]        run_r, run_nxt;
  logic [7:0]         held_r, held_nxt;
  logic               bad_r, bad_nxt;
  logic               half_r, half_nxt;
  logic [7:0]         lflag_r, lflag_nxt;
  logic [7:0]         rep_r, rep_nxt;
  logic               end_r, end_nxt;
  logic [7:0]         flag_rd_r;
  logic [31:0]        x_rd_r;
  logic [15:0]        ep_rd_r;

  // output register
  logic               ov_r;
  logic [31:0]        ox_r, oy_r;
  logic               oon_r, ocl_r, olast_r;
  logic [2:0]         ost_r;

  // write ports and emit request
  logic               flag_we, x_we, ep_we;
  logic [AW-1:0]      flag_wa, x_wa;
  logic [EAW-1:0]     ep_wa;
  logic [7:0]         flag_wd;
  logic [31:0]        x_wd;
  logic [15:0]        ep_wd;
  logic               emit;
  logic [31:0]        e_x, e_y;
  logic               e_on, e_cl, e_last;
  logic [2:0]         e_st;

  logic               can_emit;
  logic [7:0]         b;
  logic               is_y, sh, sm, d_done;
  logic [31:0]        coord;
  logic [15:0]        word;
  logic [16:0]        pt17;
  logic [15:0]        remain;
  logic [15:0]        bc_inc;
  logic [AW-1:0]      fra;
  logic [EAW-1:0]     era;
  logic               y_chain, x_chain;

  assign can_emit = !ov_r || out_ch.ready;
  assign b        = q_item.data_byte;
  assign is_y     = (phase_r == PH_Y);
  assign sh       = is_y ? flag_rd_r[sgpd_pkg::FLAG_Y_BYTE] : flag_rd_r[sgpd_pkg::FLAG_X_BYTE];
  assign sm       = is_y ? flag_rd_r[sgpd_pkg::FLAG_Y_SAME] : flag_rd_r[sgpd_pkg::FLAG_X_SAME];
  assign word     = {held_r, b};
  assign bc_inc   = bc_r + 16'd1;
  assign pt17     = (ct_r == 16'd0) ? 17'd0 : 17'(prev_r + 17'sd1);
  assign remain   = 16'(total_r - pidx_r);
  assign x_chain  = flag_rd_r[sgpd_pkg::FLAG_X_SAME] && !flag_rd_r[sgpd_pkg::FLAG_X_BYTE];
  assign y_chain  = flag_rd_r[sgpd_pkg::FLAG_Y_SAME] && !flag_rd_r[sgpd_pkg::FLAG_Y_BYTE];
  assign fra      = pidx_nxt[AW-1:0];
  assign era      = cidx_nxt[EAW-1:0];

  // delta accumulation for one byte of the current point
  always_comb begin
    coord  = run_r;
    d_done = 1'b0;
    if (sh) begin
      coord  = sm ? run_r + {24'd0, b} : run_r - {24'd0, b};
      d_done = 1'b1;
    end else if (half_r) begin
      coord  = run_r + {{16{held_r[7]}}, held_r, b};
      d_done = 1'b1;
    end
  end

  // parser sequencer
  always_comb begin
    phase_nxt = phase_r;  seq_nxt = seq_r;    bc_nxt = bc_r;     ct_nxt = ct_r;
    prev_nxt = prev_r;    skip_nxt = skip_r;  pidx_nxt = pidx_r; total_nxt = total_r;
    cidx_nxt = cidx_r;    run_nxt = run_r;    held_nxt = held_r; bad_nxt = bad_r;
    half_nxt = half_r;    lflag_nxt = lflag_r; rep_nxt = rep_r;  end_nxt = end_r;
    flag_we = 1'b0; flag_wa = pidx_r[AW-1:0]; flag_wd = b;
    x_we = 1'b0;    x_wa = pidx_r[AW-1:0];    x_wd = coord;
    ep_we = 1'b0;   ep_wa = bc_r[EAW:1];      ep_wd = word;
    emit = 1'b0; e_x = 32'd0; e_y = 32'd0; e_on = 1'b0; e_cl = 1'b0;
    e_st = sgpd_pkg::ST_POINT; e_last = 1'b1;
    q_pop = 1'b0;

    unique case (seq_r)
      SQ_IDLE: begin
        if (q_valid && can_emit) begin
          q_pop   = 1'b1;
          end_nxt = q_item.record_end;
          seq_nxt = SQ_END;
          unique case (phase_r)
            PH_HEADER: begin
              if (bc_r == 16'd0) ct_nxt = {b, 8'd0};
              else if (bc_r == 16'd1) ct_nxt = {ct_r[15:8], b};
              bc_nxt = bc_inc;
              if (bc_inc >= 16'(sgpd_pkg::HEADER_BYTES)) begin
                bc_nxt = 16'd0;
                if (ct_nxt[15]) begin
                  emit = 1'b1; e_st = sgpd_pkg::ST_COMPOUND; phase_nxt = PH_DRAIN;
                end else if (ct_nxt > MAXC16) begin
                  emit = 1'b1; e_st = sgpd_pkg::ST_LIMIT; phase_nxt = PH_DRAIN;
                end else begin
                  phase_nxt = (ct_nxt == 16'd0) ? PH_INSTLEN : PH_ENDPTS;
                end
              end
            end
            PH_ENDPTS: begin
              if (!bc_r[0]) begin
                held_nxt = b;
              end else begin
                if ($signed({1'b0, word}) <= prev_r) bad_nxt = 1'b1;
                ep_we    = ({1'b0, bc_r[15:1]} < MAXC16);
                prev_nxt = $signed({1'b0, word});
              end
              bc_nxt = bc_inc;
              if ({1'b0, bc_inc} >= {ct_r, 1'b0}) begin
                bc_nxt    = 16'd0;
                phase_nxt = PH_INSTLEN;
              end
            end
            PH_INSTLEN: begin
              if (bc_r == 16'd0) begin
                held_nxt = b;
                bc_nxt   = 16'd1;
              end else begin
                bc_nxt    = 16'd0;
                skip_nxt  = word;
                total_nxt = pt17[PW-1:0];
                if (bad_r) begin
                  emit = 1'b1; e_st = sgpd_pkg::ST_UNORDERED; phase_nxt = PH_DRAIN;
                end else if (pt17 > MAXP17) begin
                  emit = 1'b1; e_st = sgpd_pkg::ST_LIMIT; phase_nxt = PH_DRAIN;
                end else if (word != 16'd0) begin
                  phase_nxt = PH_INSTR;
                end else if (ct_r == 16'd0) begin
                  emit = 1'b1; e_st = sgpd_pkg::ST_EMPTY; phase_nxt = PH_DRAIN;
                end else begin
                  pidx_nxt = '0; phase_nxt = PH_FLAGS;
                end
              end
            end
            PH_INSTR: begin
              skip_nxt = skip_r - 16'd1;
              if (skip_nxt == 16'd0) begin
                if (ct_r == 16'd0) begin
                  emit = 1'b1; e_st = sgpd_pkg::ST_EMPTY; phase_nxt = PH_DRAIN;
                end else begin
                  pidx_nxt = '0; phase_nxt = PH_FLAGS;
                end
              end
            end
            PH_FLAGS: begin
              flag_we   = ({{(17-PW){1'b0}}, pidx_r} < MAXP17);
              lflag_nxt = b;
              pidx_nxt  = pidx_r + PW'(1);
              if (b[sgpd_pkg::FLAG_RUN]) begin
                phase_nxt = PH_REPEAT;
              end else if (pidx_nxt >= total_r) begin
                pidx_nxt = '0; run_nxt = 32'd0; half_nxt = 1'b0;
                phase_nxt = PH_X; seq_nxt = SQ_CHX;
              end
            end
            PH_REPEAT: begin
              if ({8'd0, b} > remain) begin
                emit = 1'b1; e_st = sgpd_pkg::ST_OVERRUN; phase_nxt = PH_DRAIN;
              end else begin
                rep_nxt = b; seq_nxt = SQ_FILL;
              end
            end
            PH_X: begin
              if (!sh && !half_r) begin
                held_nxt = b; half_nxt = 1'b1;
              end
              if (d_done) begin
                half_nxt = 1'b0; run_nxt = coord;
                x_we     = 1'b1;
                pidx_nxt = pidx_r + PW'(1);
                seq_nxt  = SQ_CHX;
              end
            end
            PH_Y: begin
              if (!sh && !half_r) begin
                held_nxt = b; half_nxt = 1'b1;
              end
              if (d_done) begin
                half_nxt = 1'b0; run_nxt = coord;
                emit = 1'b1; e_x = x_rd_r; e_y = coord;
                e_on = flag_rd_r[sgpd_pkg::FLAG_ON];
                e_last = (pidx_r + PW'(1) == total_r);
                if ({{(16-CW){1'b0}}, cidx_r} < MAXC16 && {{(16-CW){1'b0}}, cidx_r} < ct_r
                    && {{(16-PW){1'b0}}, pidx_r} == ep_rd_r) begin
                  e_cl = 1'b1; cidx_nxt = cidx_r + CW'(1);
                end
                pidx_nxt = pidx_r + PW'(1);
                seq_nxt  = SQ_CHY;
              end
            end
            default: ;
          endcase
        end
      end
      // repeat run: copy the last flag once per cycle
      SQ_FILL: begin
        if (rep_r != 8'd0 && {{(17-PW){1'b0}}, pidx_r} < MAXP17) begin
          flag_we = 1'b1; flag_wd = lflag_r;
          pidx_nxt = pidx_r + PW'(1);
          rep_nxt  = rep_r - 8'd1;
        end else if (pidx_r >= total_r) begin
          pidx_nxt = '0; run_nxt = 32'd0; half_nxt = 1'b0;
          phase_nxt = PH_X; seq_nxt = SQ_CHX;
        end else begin
          phase_nxt = PH_FLAGS; seq_nxt = SQ_END;
        end
      end
      // points whose x repeats the previous one
      SQ_CHX: begin
        if (pidx_r < total_r && x_chain) begin
          x_we = 1'b1; x_wd = run_r;
          pidx_nxt = pidx_r + PW'(1);
        end else if (pidx_r < total_r) begin
          phase_nxt = PH_X; seq_nxt = SQ_END;
        end else begin
          pidx_nxt = '0; run_nxt = 32'd0; half_nxt = 1'b0; cidx_nxt = '0;
          phase_nxt = PH_Y; seq_nxt = SQ_CHY;
        end
      end
      // points whose y repeats the previous one
      SQ_CHY: begin
        if (pidx_r < total_r && y_chain) begin
          if (can_emit) begin
            emit = 1'b1; e_x = x_rd_r; e_y = run_r;
            e_on = flag_rd_r[sgpd_pkg::FLAG_ON];
            e_last = (pidx_r + PW'(1) == total_r);
            if ({{(16-CW){1'b0}}, cidx_r} < MAXC16 && {{(16-CW){1'b0}}, cidx_r} < ct_r
                && {{(16-PW){1'b0}}, pidx_r} == ep_rd_r) begin
              e_cl = 1'b1; cidx_nxt = cidx_r + CW'(1);
            end
            pidx_nxt = pidx_r + PW'(1);
          end
        end else if (pidx_r < total_r) begin
          phase_nxt = PH_Y; seq_nxt = SQ_END;
        end else begin
          phase_nxt = PH_DRAIN; seq_nxt = SQ_END;
        end
      end
      // end of byte: on a record end, flag truncation and restart the glyph
      SQ_END: begin
        if (!end_r) begin
          seq_nxt = SQ_IDLE;
        end else if (phase_r == PH_DRAIN || can_emit) begin
          if (phase_r != PH_DRAIN) begin
            emit = 1'b1; e_st = sgpd_pkg::ST_TRUNCATED;
          end
          phase_nxt = PH_HEADER; bc_nxt = 16'd0; ct_nxt = 16'd0; prev_nxt = -17'sd1;
          skip_nxt = 16'd0; pidx_nxt = '0; run_nxt = 32'd0; held_nxt = 8'd0;
          bad_nxt = 1'b0; cidx_nxt = '0; total_nxt = '0; half_nxt = 1'b0;
          end_nxt = 1'b0; seq_nxt = SQ_IDLE;
        end
      end
      default: seq_nxt = SQ_IDLE;
    endcase
  end

  // stores with registered read of the next index and write bypass
  always_ff @(posedge clk) begin
    if (flag_we) flag_mem[flag_wa] <= flag_wd;
    if (x_we) x_mem[x_wa] <= x_wd;
    if (ep_we) ep_mem[ep_wa] <= ep_wd;
    flag_rd_r <= (flag_we && flag_wa == fra) ? flag_wd : flag_mem[fra];
    x_rd_r    <= (x_we && x_wa == fra) ? x_wd : x_mem[fra];
    ep_rd_r   <= (ep_we && ep_wa == era) ? ep_wd : ep_mem[era];
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER; seq_r <= SQ_IDLE; bc_r <= 16'd0; ct_r <= 16'd0;
      prev_r <= -17'sd1; skip_r <= 16'd0; pidx_r <= '0; total_r <= '0;
      cidx_r <= '0; run_r <= 32'd0; held_r <= 8'd0; bad_r <= 1'b0;
      half_r <= 1'b0; rep_r <= 8'd0; end_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; seq_r <= seq_nxt; bc_r <= bc_nxt; ct_r <= ct_nxt;
      prev_r <= prev_nxt; skip_r <= skip_nxt; pidx_r <= pidx_nxt; total_r <= total_nxt;
      cidx_r <= cidx_nxt; run_r <= run_nxt; held_r <= held_nxt; bad_r <= bad_nxt;
      half_r <= half_nxt; rep_r <= rep_nxt; end_r <= end_nxt;
      if (emit) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
    end
    lflag_r <= lflag_nxt;
    if (emit) begin
      ox_r <= e_x; oy_r <= e_y; oon_r <= e_on; ocl_r <= e_cl;
      ost_r <= e_st; olast_r <= e_last;
    end
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.point_x        = ox_r;
  assign out_ch.point_y        = oy_r;
  assign out_ch.curve_pt       = oon_r;
  assign out_ch.closes_contour = ocl_r;
  assign out_ch.status         = ost_r;
  assign out_ch.last           = olast_r;

`ifndef SYNTHESIS
  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> can_emit) else $error("result overwritten");
  a_err_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && e_st != sgpd_pkg::ST_POINT) |=> (phase_r == PH_DRAIN || phase_r == PH_HEADER))
    else $error("error result without drain");
  a_pidx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {{(17-PW){1'b0}}, pidx_r} <= MAXP17) else $error("point index out of range");
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && e_st != sgpd_pkg::ST_POINT) |-> e_last) else $error("error result not last");
`endif

endmodule

### design/simple_glyph_point_decoder.sv
// Simple glyph point decoder: takes one glyph record byte per transfer and
// returns one result per point, or one status result on error or empty glyph.
// The parser sequencer takes each byte from the queue and then checks for the
// end of the record. After a repeat count it copies the last flag once for
// each repeat. After a byte that completes the flags or a coordinate, it looks
// ahead and settles each following point whose x or y is unchanged, one point
// per cycle while no pending result holds the y points.
// A pending result that is not taken holds the sequencer. A two-entry byte
// queue lets input keep arriving while a result waits to be taken.
// Depends on sgpd_pkg, sgpd_if, sgpd_front and sgpd_back.
module simple_glyph_point_decoder #(
  parameter int MAX_POINTS   = 64,
  parameter int MAX_CONTOURS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  sgpd_in_if.sink     in_ch,
  sgpd_out_if.source  out_ch
);

  sgpd_pkg::item_t in_item, q_item;
  logic            q_valid, q_pop;

  assign in_item.data_byte  = in_ch.data_byte;
  assign in_item.record_end = in_ch.record_end;

  // input queue
  sgpd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // parser and result register
  sgpd_back #(
    .MAX_POINTS   (MAX_POINTS),
    .MAX_CONTOURS (MAX_CONTOURS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

### verif/tb_simple_glyph_point_decoder.sv
// Testbench for simple_glyph_point_decoder: builds glyph records and streams
// them byte by byte, predicts each point and status, and checks every result.
// Depends on sgpd_pkg, sgpd_if and the decoder RTL.
`timescale 1ns / 100ps

module tb_simple_glyph_point_decoder;

  localparam int NPTS  = 64;
  localparam int NCONT = 16;
  localparam int IDLE_LIMIT = 4000;
  localparam int RAND_BYTES = 430;

  // Decode phases of the predictor
  typedef enum int {
    P_HEADER, P_ENDPTS, P_INSTLEN, P_INSTR, P_FLAGS, P_REPEAT, P_X, P_Y, P_DRAIN
  } phase_t;

  // Glyph shapes the generator can build
  typedef enum int {
    G_GOOD, G_ALLSAME, G_MAXPTS, G_COMPOUND, G_MANYCONT, G_UNORDER,
    G_MANYPTS, G_OVERRUN, G_EMPTY, G_TRUNC, G_NOISE, G_COUNT
  } glyph_kind_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               on;
    logic               cl;
    sgpd_pkg::status_t  st;
    logic               last;
  } point_rec_t;

  // Point predictor and queue of expected results
  class glyph_scoreboard;
    point_rec_t   pts_q[$];
    int           fails;
    phase_t       phase;
    logic [31:0]  bcnt, ctot, skip, pidx, run, held, cidx, ptot;
    int           prev_ep;
    bit           bad;
    logic [15:0]  ep_st[NCONT];
    logic [7:0]   fl_st[NPTS];
    logic [31:0]  x_st[NPTS];

    function new();
      fails = 0;
      restart();
    endfunction

    function void restart();
      phase = P_HEADER; bcnt = 0; ctot = 0; prev_ep = -1; skip = 0;
      pidx = 0; run = 0; held = 0; bad = 0; cidx = 0; ptot = 0;
    endfunction

    function void put(logic [31:0] x, logic [31:0] y, logic on, logic cl,
                      sgpd_pkg::status_t st, logic last);
      point_rec_t r;
      r.x = x; r.y = y; r.on = on; r.cl = cl; r.st = st; r.last = last;
      pts_q.insert(pts_q.size(), r);
    endfunction

    function void abort(sgpd_pkg::status_t st);
      put(0, 0, 0, 0, st, 1);
      phase = P_DRAIN;
    endfunction

    function void emit_point();
      logic cl;
      cl = 0;
      if (cidx < NCONT && cidx < ctot && pidx == {16'd0, ep_st[cidx]}) begin
        cl = 1;
        cidx++;
      end
      put(x_st[pidx], run, fl_st[pidx][sgpd_pkg::FLAG_ON], cl, sgpd_pkg::ST_POINT,
          pidx + 1 == ptot);
      pidx++;
    endfunction

    function void chain_y();
      while (pidx < ptot) begin
        if (fl_st[pidx][sgpd_pkg::FLAG_Y_BYTE] || !fl_st[pidx][sgpd_pkg::FLAG_Y_SAME]) return;
        emit_point();
      end
      phase = P_DRAIN;
    endfunction

    function void chain_x();
      while (pidx < ptot) begin
        if (fl_st[pidx][sgpd_pkg::FLAG_X_BYTE] || !fl_st[pidx][sgpd_pkg::FLAG_X_SAME]) return;
        x_st[pidx] = run;
        pidx++;
      end
      pidx = 0; run = 0; bcnt = 0; cidx = 0;
      phase = P_Y;
      chain_y();
    endfunction

    function void after_instr();
      if (ctot == 0) begin
        abort(sgpd_pkg::ST_EMPTY);
        return;
      end
      pidx = 0;
      phase = P_FLAGS;
    endfunction

    function void flags_done();
      if (pidx >= ptot) begin
        pidx = 0; run = 0; bcnt = 0;
        phase = P_X;
        chain_x();
      end else phase = P_FLAGS;
    endfunction

    // One delta byte; returns 1 once the coordinate is complete
    function bit add_delta(logic [7:0] b, logic [7:0] f, int sbit, int same);
      logic [31:0] d;
      if (f[sbit]) begin
        if (f[same]) run += {24'd0, b};
        else run -= {24'd0, b};
        return 1;
      end
      if (bcnt == 0) begin
        held = {24'd0, b};
        bcnt = 1;
        return 0;
      end
      d = {{16{held[7]}}, held[7:0], b};
      run += d;
      bcnt = 0;
      return 1;
    endfunction

    // Accepted input transfer: advance the predictor
    function void note_byte(logic [7:0] b, logic e);
      logic [31:0] v;
      logic [7:0]  f;
      int          k;
      case (phase)
        P_HEADER: begin
          if (bcnt == 0) ctot = {16'd0, b, 8'd0};
          else if (bcnt == 1) ctot |= {24'd0, b};
          bcnt++;
          if (bcnt >= sgpd_pkg::HEADER_BYTES) begin
            bcnt = 0;
            if (ctot[15]) abort(sgpd_pkg::ST_COMPOUND);
            else if (ctot > NCONT) abort(sgpd_pkg::ST_LIMIT);
            else phase = (ctot == 0) ? P_INSTLEN : P_ENDPTS;
          end
        end
        P_ENDPTS: begin
          if (!bcnt[0]) held = {24'd0, b};
          else begin
            v = {held[23:0], b};
            if ($signed(v) <= prev_ep) bad = 1;
            if ((bcnt >> 1) < NCONT) ep_st[bcnt >> 1] = v[15:0];
            prev_ep = v;
          end
          bcnt++;
          if (bcnt >= 2 * ctot) begin
            bcnt = 0;
            phase = P_INSTLEN;
          end
        end
        P_INSTLEN: begin
          if (bcnt == 0) begin
            held = {24'd0, b};
            bcnt = 1;
          end else begin
            bcnt = 0;
            skip = {held[23:0], b};
            ptot = (ctot == 0) ? 0 : prev_ep + 1;
            if (bad) abort(sgpd_pkg::ST_UNORDERED);
            else if (ptot > NPTS) abort(sgpd_pkg::ST_LIMIT);
            else if (skip == 0) after_instr();
            else phase = P_INSTR;
          end
        end
        P_INSTR: begin
          skip--;
          if (skip == 0) after_instr();
        end
        P_FLAGS: begin
          if (pidx < NPTS) fl_st[pidx] = b;
          pidx++;
          if (b[sgpd_pkg::FLAG_RUN]) phase = P_REPEAT;
          else flags_done();
        end
        P_REPEAT: begin
          if ({24'd0, b} > ptot - pidx) abort(sgpd_pkg::ST_OVERRUN);
          else begin
            f = fl_st[pidx - 1];
            for (k = 0; k < b && pidx < NPTS; k++) begin
              fl_st[pidx] = f;
              pidx++;
            end
            flags_done();
          end
        end
        P_X: begin
          if (add_delta(b, fl_st[pidx], sgpd_pkg::FLAG_X_BYTE, sgpd_pkg::FLAG_X_SAME)) begin
            x_st[pidx] = run;
            pidx++;
            chain_x();
          end
        end
        P_Y: begin
          if (add_delta(b, fl_st[pidx], sgpd_pkg::FLAG_Y_BYTE, sgpd_pkg::FLAG_Y_SAME)) begin
            emit_point();
            chain_y();
          end
        end
        default: ;
      endcase
      if (e) begin
        if (phase != P_DRAIN) put(0, 0, 0, 0, sgpd_pkg::ST_TRUNCATED, 1);
        restart();
      end
    endfunction

    // Accepted result transfer: compare with the oldest expectation
    function void check_point(point_rec_t got);
      point_rec_t want;
      if (pts_q.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d st=%0d", $realtime,
                 got.x, got.y, got.st);
        fails++;
        return;
      end
      want = pts_q.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.on !== want.on ||
          got.cl !== want.cl || got.st !== want.st || got.last !== want.last) begin
        $display("%0t: mismatch expected x=%0d y=%0d on=%0b cl=%0b st=%0d last=%0b",
                 $realtime, want.x, want.y, want.on, want.cl, want.st, want.last);
        $display("%0t:          actual x=%0d y=%0d on=%0b cl=%0b st=%0d last=%0b",
                 $realtime, got.x, got.y, got.on, got.cl, got.st, got.last);
        fails++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  sgpd_in_if  in_ch();
  sgpd_out_if out_ch();

  simple_glyph_point_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  glyph_scoreboard sb = new();
  logic [8:0] glyph_q[$];   // {record_end, data_byte}
  int burst_left = 0;
  int sent = 0;
  int idle_cycles = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Glyph record generation
  function void add_byte(logic [8:0] item);
    glyph_q.insert(glyph_q.size(), item);
  endfunction

  function void push16(logic [15:0] w);
    add_byte({1'b0, w[15:8]});
    add_byte({1'b0, w[7:0]});
  endfunction

  function void build_glyph(glyph_kind_t kind);
    int nc, np, n, i, j, cnt;
    int ep[NCONT];
    logic [7:0] fl[NPTS];
    logic [7:0] f;
    bit stop;
    glyph_q.delete();
    stop = 0;
    case (kind)
      G_COMPOUND, G_MANYCONT, G_EMPTY: begin
        if (kind == G_COMPOUND) push16(16'h8000 | 16'($urandom_range(0, 16'h7fff)));
        else if (kind == G_MANYCONT) push16(16'($urandom_range(NCONT + 1, 16'h7fff)));
        else push16(16'd0);
        repeat (8) add_byte({1'b0, 8'($urandom)});
        if (kind == G_EMPTY) begin
          n = $urandom_range(0, 3);
          push16(16'(n));
          repeat (n) add_byte({1'b0, 8'($urandom)});
        end
      end
      G_NOISE: repeat ($urandom_range(1, 40)) add_byte({1'b0, 8'($urandom)});
      default: begin
        nc = (kind == G_MAXPTS) ? $urandom_range(1, NCONT) : $urandom_range(1, 4);
        if (kind == G_UNORDER && nc < 2) nc = 2;
        np = (kind == G_MAXPTS) ? NPTS : $urandom_range(nc, 12);
        for (i = 0; i < nc - 1; i++)
          ep[i] = $urandom_range(i == 0 ? 0 : ep[i - 1] + 1, np - (nc - i));
        ep[nc - 1] = np - 1;
        if (kind == G_UNORDER) begin
          j = $urandom_range(1, nc - 1);
          ep[j] = $urandom_range(0, ep[j - 1]);
        end
        if (kind == G_MANYPTS) ep[nc - 1] = $urandom_range(NPTS, 16'hffff);
        push16(16'(nc));
        repeat (8) add_byte({1'b0, 8'($urandom)});
        for (i = 0; i < nc; i++) push16(16'(ep[i]));
        n = ($urandom_range(0, 15) == 0) ? 256 : $urandom_range(0, 3);
        push16(16'(n));
        repeat (n) add_byte({1'b0, 8'($urandom)});
        if (kind != G_UNORDER && kind != G_MANYPTS) begin
          // flags with repeat runs
          i = 0;
          while (i < np && !stop) begin
            f = 8'($urandom);
            if (kind == G_ALLSAME) begin
              f[sgpd_pkg::FLAG_X_BYTE] = 0; f[sgpd_pkg::FLAG_Y_BYTE] = 0;
              f[sgpd_pkg::FLAG_X_SAME] = 1; f[sgpd_pkg::FLAG_Y_SAME] = 1;
            end
            f[sgpd_pkg::FLAG_RUN] = (kind == G_OVERRUN && i == 0) ||
                                    $urandom_range(0, 3) == 0;
            add_byte({1'b0, f});
            fl[i] = f;
            i++;
            if (f[sgpd_pkg::FLAG_RUN]) begin
              if (kind == G_OVERRUN) begin
                cnt = np - i + $urandom_range(1, 5);
                if (cnt > 255) cnt = 255;
                stop = 1;
              end else cnt = $urandom_range(0, np - i);
              add_byte({1'b0, 8'(cnt)});
              for (j = 0; j < cnt && !stop; j++) begin
                fl[i] = f;
                i++;
              end
            end
          end
          if (!stop) begin
            for (i = 0; i < np; i++)
              if (fl[i][sgpd_pkg::FLAG_X_BYTE]) add_byte({1'b0, 8'($urandom)});
              else if (!fl[i][sgpd_pkg::FLAG_X_SAME]) push16(16'($urandom));
            for (i = 0; i < np; i++)
              if (fl[i][sgpd_pkg::FLAG_Y_BYTE]) add_byte({1'b0, 8'($urandom)});
              else if (!fl[i][sgpd_pkg::FLAG_Y_SAME]) push16(16'($urandom));
          end
        end
      end
    endcase
    if (kind == G_TRUNC && glyph_q.size() > 1)
      glyph_q = glyph_q[0:$urandom_range(0, glyph_q.size() - 2)];
    // occasional trailing bytes after the glyph
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) add_byte({1'b0, 8'($urandom)});
    glyph_q[glyph_q.size() - 1][8] = 1'b1;
  endfunction

  // Present one byte and hold it until its transfer
  task send_byte(logic [8:0] item);
    if (burst_left == 0) begin
      in_ch.valid = 0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_ch.valid      = 1;
    in_ch.data_byte  = item[7:0];
    in_ch.record_end = item[8];
    do @(posedge clk); while (!in_ch.ready);
    sb.note_byte(item[7:0], item[8]);
    sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task send_glyph(glyph_kind_t kind);
    build_glyph(kind);
    foreach (glyph_q[i]) send_byte(glyph_q[i]);
  endtask

  // Receiver stall pattern: a randomly chosen mode of always ready, random ready or a repeating ready pattern
  initial begin
    int mode, cyc;
    out_ch.ready = 0;
    mode = 0;
    cyc = 0;
    forever begin
      @(negedge clk);
      if (cyc % 300 == 0) mode = $urandom_range(0, 2);
      cyc++;
      case (mode)
        0: out_ch.ready = 1;
        1: out_ch.ready = $urandom_range(0, 1);
        default: out_ch.ready = (cyc % 5) < 3;
      endcase
    end
  end

  // Result transfers go to the scoreboard
  always @(posedge clk) begin
    point_rec_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.x = out_ch.point_x; got.y = out_ch.point_y;
      got.on = out_ch.curve_pt; got.cl = out_ch.closes_contour;
      got.st = sgpd_pkg::status_t'(out_ch.status); got.last = out_ch.last;
      sb.check_point(got);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Main sequence
  initial begin
    in_ch.valid = 0;
    in_ch.data_byte = 0;
    in_ch.record_end = 0;
    rst_n = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: one glyph of each shape
    for (int k = 0; k < G_COUNT; k++) send_glyph(glyph_kind_t'(k));

    // random: mostly well-formed glyphs
    while (sent < RAND_BYTES) begin
      if ($urandom_range(0, 9) < 6) send_glyph($urandom_range(0, 1) ? G_GOOD : G_ALLSAME);
      else send_glyph(glyph_kind_t'($urandom_range(0, G_COUNT - 1)));
    end

    in_ch.valid = 0;
    while (sb.pts_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.fails == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

### files.f
design/sgpd_pkg.sv
design/sgpd_if.sv
design/sgpd_front.sv
design/sgpd_back.sv
design/simple_glyph_point_decoder.sv
verif/tb_simple_glyph_point_decoder.sv
